// ===== design/tapsa_pkg.sv =====
// Package for the two-axis PID servo block: register indexes, widths, types.
// No dependencies.
`default_nettype none
package tapsa_pkg;
  localparam int PosW   = 12;
  localparam int TimeW  = 32;
  localparam int AngW   = 8;
  localparam int GainW  = 16;
  localparam int IntW   = 32;
  localparam int AddrW  = 5;

  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_CENTER = 3'd3,
    REG_LOW    = 3'd4,
    REG_HIGH   = 3'd5,
    REG_SPAN   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [7:0]              center;
    logic signed [8:0]       low;
    logic [7:0]              high;
    logic [10:0]             span;
  } cfg_t;

  // Lane control: start a sample, clear integrator.
  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ===== design/tapsa_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface tapsa_if #(parameter int W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tapsa_div.sv =====
// Restoring divider, signed dividend by unsigned divisor, truncation to zero.
// One quotient bit per cycle. Depends on nothing.
`default_nettype none
module tapsa_div #(
  parameter int NW = 40,
  parameter int DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [DW-1:0]        den,
  output logic                      done,
  output logic signed [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic          neg_r, busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial;
  logic [NW-1:0] mag;

  assign mag = num[NW-1] ? NW'(-num) : num;

  // Shift in one dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt = {q_r[NW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(NW);
        q_r <= mag;
        rem_r <= '0;
        den_r <= den;
        neg_r <= num[NW-1];
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restore the sign of the finished quotient.
  assign quo = neg_r ? NW'(-q_r) : q_r;
endmodule
`default_nettype wire

// ===== design/tapsa_lane.sv =====
// One axis of the PID: map, P, saturating integrator, D with divider, clamp.
// Uses tapsa_pkg and tapsa_div.
`default_nettype none
module tapsa_lane (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tapsa_pkg::lane_ctl_t  ctl,
  input  wire tapsa_pkg::cfg_t       cfg,
  input  wire logic signed [11:0]    pos,
  input  wire logic [31:0]           dt,
  output logic                       done,
  output logic [7:0]                 angle
);
  import tapsa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MAP, S_MAPQ, S_MUL, S_SUM, S_DIV, S_OUT}
    st_t;
  st_t st_r;

  logic signed [IntW-1:0] int_r;
  logic signed [PosW-1:0] prev_r;
  logic signed [PosW-1:0] pos_r;
  logic [31:0]            dt_r;
  logic signed [22:0]     mnum_r;
  logic [11:0]            span2_r;
  logic signed [22:0]     m_r;
  logic signed [39:0]     p_r, istep_r;
  logic signed [33:0]     dnum_r;
  logic signed [42:0]     tot_r;
  logic                   mdiv_start, ddiv_start, mdone, ddone;
  logic signed [22:0]     mquo;
  logic signed [39:0]     dquo;
  logic [10:0]            span;
  logic signed [41:0]     acc;
  logic signed [IntW-1:0] acc_sat;
  logic signed [42:0]     hi, lo, tot_c;
  logic signed [34:0]     deg;

  assign span = (cfg.span == '0) ? 11'd1 : cfg.span;

  // Map divider: offset numerator over twice the span.
  tapsa_div #(.NW(23), .DW(12)) u_mdiv (
    .clk, .rst_n, .start(mdiv_start), .num(mnum_r), .den(span2_r),
    .done(mdone), .quo(mquo));
  // D divider: gain times position step over dt.
  tapsa_div #(.NW(40), .DW(32)) u_ddiv (
    .clk, .rst_n, .start(ddiv_start), .num(40'(dnum_r)), .den(dt_r),
    .done(ddone), .quo(dquo));

  assign mdiv_start = (st_r == S_MAP);
  assign ddiv_start = (st_r == S_SUM) && (dt_r != '0);

  always_comb begin
    acc = 42'(int_r) + 42'(istep_r);
    if (acc > 42'sd2147483647) acc_sat = 32'sh7fffffff;
    else if (acc < -42'sd2147483648) acc_sat = 32'sh80000000;
    else acc_sat = acc[31:0];
    hi = 43'((11'(cfg.center) + 11'(cfg.high))) <<< 16;
    lo = 43'(($signed({2'b0, cfg.center}) + 11'(cfg.low))) <<< 16;
    tot_c = tot_r;
    if (tot_r > hi) tot_c = hi;
    else if (tot_r < lo) tot_c = lo;
    deg = 35'(tot_c[42:16]);
  end

  // Sequence one sample through map, multiply, divide and clamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      int_r <= '0;
      prev_r <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.clear) int_r <= '0;
      case (st_r)
        S_IDLE: if (ctl.start) begin
          pos_r <= pos;
          dt_r <= dt;
          mnum_r <= (23'(pos) + 23'($signed({1'b0, span}))) *
                    (23'($signed({1'b0, cfg.high})) - 23'(cfg.low));
          span2_r <= {span, 1'b0};
          st_r <= S_MAP;
        end
        S_MAP: st_r <= S_MAPQ;
        S_MAPQ: if (mdone) begin
          m_r <= mquo + 23'(cfg.low);
          st_r <= S_MUL;
        end
        S_MUL: begin
          p_r <= 40'(cfg.kp * m_r) <<< 4;
          istep_r <= 40'(cfg.ki * m_r) <<< 4;
          dnum_r <= 34'(cfg.kd * 18'(13'(pos_r) - 13'(prev_r))) <<< 4;
          st_r <= S_SUM;
        end
        S_SUM: begin
          int_r <= acc_sat;
          prev_r <= pos_r;
          st_r <= (dt_r != '0) ? S_DIV : S_OUT;
          tot_r <= 43'(p_r) + 43'(acc_sat) + (43'($signed({1'b0, cfg.center})) <<< 16);
        end
        S_DIV: if (ddone) begin
          tot_r <= tot_r + 43'(dquo);
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (tot_c < 0) angle <= '0;
          else if (deg > 35'sd180) angle <= 8'd180;
          else angle <= deg[7:0];
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/two_axis_pid_servo_angle.sv =====
// Top level: APB registers, input/output channels, axis lanes and merge.
// Uses tapsa_pkg, tapsa_if, tapsa_lane.
//
// An accepted beat with a nonzero position reaches the output register after
// every axis lane has run a 23-step divider for the position map and then, when
// its time step is nonzero, a 40-step divider for the D term, one quotient bit
// per cycle, with all lanes in parallel. The next beat is taken from the cycle
// after the result moves to the output register, so a new sample is not taken
// while the last one is still in the lanes. A beat with all positions zero
// clears the integrators and gives no result.
// The output register parts the two sides: a new beat may enter while a
// result waits there; a second finished result waits in the lanes and holds
// off the input until the output register frees up.
`default_nettype none
module two_axis_pid_servo_angle #(
  parameter int AXES = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tapsa_if.sink                           in_ch,
  tapsa_if.source                         out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [tapsa_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import tapsa_pkg::*;

  cfg_t cfg_r;
  logic busy_r, ovalid_r, held_r;
  logic [AngW-1:0] ox_r, oy_r;
  logic [TimeW-1:0] ptime_r;
  lane_ctl_t ctl;
  logic [AXES-1:0] ldone;
  logic [AngW-1:0] lang [AXES];
  logic signed [PosW-1:0] px, py;
  logic [TimeW-1:0] now;
  logic acc_in, allz, wr, out_acc, res_rdy;
  reg_idx_t ridx;

  assign px = in_ch.data[PosW-1:0];
  assign py = in_ch.data[2*PosW-1:PosW];
  assign now = in_ch.data[2*PosW+TimeW-1:2*PosW];
  assign allz = (px == '0) && ((AXES < 2) || (py == '0));
  assign in_ch.ready = !busy_r;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign ctl.start = acc_in && !allz;
  assign ctl.clear = acc_in && allz;

  // Register write and readback.
  assign cfg_pready = 1'b1;
  assign ridx = reg_idx_t'(cfg_paddr[4:2]);
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (ridx)
      REG_KP:     cfg_prdata = 32'($unsigned(cfg_r.kp));
      REG_KI:     cfg_prdata = 32'($unsigned(cfg_r.ki));
      REG_KD:     cfg_prdata = 32'($unsigned(cfg_r.kd));
      REG_CENTER: cfg_prdata = 32'(cfg_r.center);
      REG_LOW:    cfg_prdata = 32'($unsigned(cfg_r.low));
      REG_HIGH:   cfg_prdata = 32'(cfg_r.high);
      REG_SPAN:   cfg_prdata = 32'(cfg_r.span);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{kp: 16'sd4096, ki: 16'sd41, kd: 16'sd0, center: 8'd135,
                 low: -9'sd45, high: 8'd45, span: 11'd135};
    end else if (wr) begin
      case (ridx)
        REG_KP:     cfg_r.kp <= cfg_pwdata[15:0];
        REG_KI:     cfg_r.ki <= cfg_pwdata[15:0];
        REG_KD:     cfg_r.kd <= cfg_pwdata[15:0];
        REG_CENTER: cfg_r.center <= cfg_pwdata[7:0];
        REG_LOW:    cfg_r.low <= cfg_pwdata[8:0];
        REG_HIGH:   cfg_r.high <= cfg_pwdata[7:0];
        REG_SPAN:   cfg_r.span <= cfg_pwdata[10:0];
        default:    ;
      endcase
    end
  end

  // Axis lanes; extra axes see position zero.
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    logic signed [PosW-1:0] lpos;
    assign lpos = (a == 0) ? px : ((a == 1) ? py : '0);
    tapsa_lane u_lane (
      .clk, .rst_n, .ctl, .cfg(cfg_r), .pos(lpos), .dt(now - ptime_r),
      .done(ldone[a]), .angle(lang[a]));
  end

  assign out_acc = out_ch.valid && out_ch.ready;
  assign res_rdy = (busy_r && ldone[0]) || held_r;

  // Merge lane results into one output beat; hold a finished result in the
  // lanes while the output register is still full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovalid_r <= 1'b0;
      held_r <= 1'b0;
      ptime_r <= '0;
    end else begin
      if (ctl.start) begin
        busy_r <= 1'b1;
        ptime_r <= now;
      end
      if (res_rdy && (!ovalid_r || out_acc)) begin
        busy_r <= 1'b0;
        held_r <= 1'b0;
        ovalid_r <= 1'b1;
        ox_r <= lang[0];
        oy_r <= (AXES > 1) ? lang[AXES > 1 ? 1 : 0] : '0;
      end else begin
        if (busy_r && ldone[0]) held_r <= 1'b1;
        if (out_acc) ovalid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data = {oy_r, ox_r};

  // Lanes finish together; no accept while working; no result from a clear.
  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    ldone[0] |-> (&ldone)) else $error("lanes out of step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready) else $error("accept while busy");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.clear && !ovalid_r) |=> !ovalid_r) else $error("result after clear");
endmodule
`default_nettype wire

// ===== tb/two_axis_pid_servo_angle_check.sv =====
// Checker for the two-axis PID servo block: mirrors register writes, predicts
// the angles of each nonzero accepted sample and compares them to each result beat.
// Uses tapsa_pkg for register indexes and widths.
`default_nettype none
module two_axis_pid_servo_angle_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [55:0] in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [15:0] out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [tapsa_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               pending
);
  import tapsa_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0]       time_ms;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_x;
  } sample_t;

  typedef struct packed {
    logic [AngW-1:0] angle_y;
    logic [AngW-1:0] angle_x;
  } angles_t;

  cfg_t                  gains;
  logic signed [IntW-1:0] integ [2];
  logic signed [PosW-1:0] last_pos [2];
  logic [TimeW-1:0]       last_time;
  angles_t                angle_q [$];

  // One axis: map position, run the PID terms, clamp and truncate to degrees.
  function automatic logic [AngW-1:0] axis_angle(int ax, longint pos, logic [TimeW-1:0] dt);
    longint span, m, p, acc, d, total, hi, lo;
    span = (gains.span == 0) ? 1 : longint'(gains.span);
    m = ((pos + span) * (longint'(gains.high) - longint'(gains.low))) / (2 * span)
        + longint'(gains.low);
    p = longint'(gains.kp) * m * 16;
    acc = longint'(integ[ax]) + longint'(gains.ki) * m * 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    integ[ax] = acc[IntW-1:0];
    d = 0;
    if (dt != 0)
      d = (longint'(gains.kd) * (pos - longint'(last_pos[ax])) * 16) / longint'({32'b0, dt});
    total = p + acc + d + longint'(gains.center) * 65536;
    hi = (longint'(gains.center) + longint'(gains.high)) * 65536;
    lo = (longint'(gains.center) + longint'(gains.low)) * 65536;
    if (total > hi) total = hi;
    else if (total < lo) total = lo;
    if (total < 0) return '0;
    total = total >>> 16;
    return (total > 180) ? 8'd180 : total[AngW-1:0];
  endfunction

  // Step the servo state for one sample; returns 1 when a result is due.
  function automatic bit servo_step(sample_t s, output angles_t a);
    logic [TimeW-1:0] dt;
    dt = s.time_ms - last_time;
    if (s.pos_x == 0 && s.pos_y == 0) begin
      integ[0] = '0;
      integ[1] = '0;
      return 0;
    end
    a.angle_x = axis_angle(0, longint'(s.pos_x), dt);
    a.angle_y = axis_angle(1, longint'(s.pos_y), dt);
    last_pos[0] = s.pos_x;
    last_pos[1] = s.pos_y;
    last_time = s.time_ms;
    return 1;
  endfunction

  always @(posedge clk) begin
    angles_t want, got;
    if (!rst_n) begin
      gains = '{kp: 16'sd4096, ki: 16'sd41, kd: 16'sd0, center: 8'd135,
                low: -9'sd45, high: 8'd45, span: 11'd135};
      integ[0] = '0; integ[1] = '0;
      last_pos[0] = '0; last_pos[1] = '0;
      last_time = '0;
      angle_q.delete();
      mismatches = 0;
    end else begin
      // mirror register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_KP:     gains.kp = cfg_pwdata[15:0];
          REG_KI:     gains.ki = cfg_pwdata[15:0];
          REG_KD:     gains.kd = cfg_pwdata[15:0];
          REG_CENTER: gains.center = cfg_pwdata[7:0];
          REG_LOW:    gains.low = cfg_pwdata[8:0];
          REG_HIGH:   gains.high = cfg_pwdata[7:0];
          REG_SPAN:   gains.span = cfg_pwdata[10:0];
          default: ;
        endcase
      end
      // predict on each accepted sample beat
      if (in_valid && in_ready)
        if (servo_step(sample_t'(in_data), want)) angle_q.push_back(want);
      // compare each result beat with the oldest prediction
      if (out_valid && out_ready) begin
        got = angles_t'(out_data);
        if (angle_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: angle_x=%0d angle_y=%0d",
                     got.angle_x, got.angle_y);
        end else begin
          want = angle_q.pop_front();
          if (got.angle_x !== want.angle_x || got.angle_y !== want.angle_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("angle mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.angle_x, want.angle_y, got.angle_x, got.angle_y);
          end
        end
      end
    end
    pending = angle_q.size();
  end
endmodule
`default_nettype wire

// ===== tb/two_axis_pid_servo_angle_test.sv =====
// Testbench top for the two-axis PID servo block: clock, reset, register
// phases, sample stimulus and result back-pressure; verdict from the checker.
// Uses tapsa_pkg, tapsa_if, two_axis_pid_servo_angle and its checker.
`default_nettype none
module two_axis_pid_servo_angle_test;
  import tapsa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int mismatches, pending;
  int cycles = 0;
  bit hold_req = 1'b0;
  logic [31:0] now_ms = '0;
  int cur_span = 135;

  tapsa_if #(.W(56)) in_ch (clk);
  tapsa_if #(.W(16)) out_ch (clk);

  two_axis_pid_servo_angle u_top (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  two_axis_pid_servo_angle_check u_check (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .pending
  );

  always #6 clk = ~clk;

  // cap the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  // register write: setup beat, then access beat
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AddrW'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic load_regs(int kp, int ki, int kd, int center, int low, int high, int span);
    reg_write(REG_KP, kp);
    reg_write(REG_KI, ki);
    reg_write(REG_KD, kd);
    reg_write(REG_CENTER, center);
    reg_write(REG_LOW, low);
    reg_write(REG_HIGH, high);
    reg_write(REG_SPAN, span);
    cur_span = (span & 11'h7ff) == 0 ? 1 : span & 11'h7ff;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // offer one sample beat, hold until accepted, then maybe idle
  task automatic send_sample(logic [11:0] px, logic [11:0] py, logic [31:0] t);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= {t, py, px};
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [11:0] pick_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 12'($urandom_range(0, 2 * cur_span + 4) - cur_span - 2);
    if (r < 19) return 12'($urandom);
    return 12'd0;
  endfunction

  task automatic send_random(int count);
    logic [11:0] px, py;
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        px = 0; py = 0;
      end else begin
        px = pick_pos();
        py = pick_pos();
      end
      r = $urandom_range(0, 99);
      if (r < 3) now_ms = $urandom;
      else if (r >= 12) now_ms = now_ms + $urandom_range(1, 25);
      send_sample(px, py, now_ms);
    end
  endtask

  // let the block finish any work before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, ball at centre, zero time step, time wrap
    send_sample(12'sd2047, -12'sd2048, 32'd10);
    send_sample(-12'sd2048, 12'sd2047, 32'd10);
    send_sample(12'd0, 12'd0, 32'd11);
    send_sample(12'd0, 12'sd5, 32'd12);
    send_sample(-12'sd135, 12'sd0, 32'd13);
    send_sample(12'sd135, 12'sd134, 32'hFFFF_FFFF);
    send_sample(12'sd1, -12'sd1, 32'd4);
    drain();
    load_regs(32767, 32767, -32768, 180, -180, 180, 1);
    send_sample(12'sd1, -12'sd1, 32'd100);
    send_sample(-12'sd1, 12'sd1, 32'd101);
    send_sample(12'sd2047, -12'sd2048, 32'd101);
    send_sample(12'd0, 12'd0, 32'd102);
    send_sample(-12'sd2048, 12'sd2047, 32'hFFFF_FFFF);
    drain();
    load_regs(-32768, -32768, 32767, 0, 0, 0, 2047);
    send_sample(12'sd2047, -12'sd2048, 32'd0);
    send_sample(-12'sd2048, 12'sd2047, 32'd1);
    send_sample(12'sd1000, 12'sd3, 32'd1);
    drain();
    // crossed limits, centre past the field, zero span
    load_regs(20000, 3000, 9000, 250, 100, 10, 0);
    send_sample(12'sd1, -12'sd1, 32'd50);
    send_sample(-12'sd2, 12'sd2, 32'd60);
    drain();

    // random phases over several register settings
    load_regs(4096, 41, 0, 135, -45, 45, 135);
    hold_req <= 1'b1;
    send_random(150);
    drain();
    load_regs(32767, 32767, -32768, 180, -180, 180, 1);
    send_random(100);
    drain();
    load_regs(-32768, -32768, 32767, 0, 0, 0, 2047);
    send_random(100);
    drain();
    load_regs(20000, 3000, 9000, 250, 255, 10, 0);
    send_random(80);
    drain();
    repeat (4) begin
      load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_random(110);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== two_axis_pid_servo_angle.f =====
design/tapsa_pkg.sv
design/tapsa_if.sv
design/tapsa_div.sv
design/tapsa_lane.sv
design/two_axis_pid_servo_angle.sv
tb/two_axis_pid_servo_angle_check.sv
tb/two_axis_pid_servo_angle_test.sv
